// ===== hw/rtl/pca_pkg.sv =====
// pca_pkg: shared types and constants for the palette colour allocator.
// Used by pca_cell and palette_colour_allocator; no dependencies.
package pca_pkg;
  localparam int PAL_DEPTH = 256;
  localparam int IDX_W     = $clog2(PAL_DEPTH);
  localparam int CNT_W     = IDX_W + 1;
  localparam int CHAN_W    = 16;
  localparam int DIST_W    = 18;
  localparam int PADDR_W   = 3;

  localparam logic [PADDR_W-1:0] ADDR_NUM_COLOURS = 3'd0;
  localparam logic [CNT_W-1:0]   NUM_COLOURS_RST  = CNT_W'(PAL_DEPTH);

  localparam logic [1:0] OUT_EXACT = 2'd0;
  localparam logic [1:0] OUT_FREE  = 2'd1;
  localparam logic [1:0] OUT_NEAR  = 2'd2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic  valid;
    rgb_t  req;
    logic  hit_ok;
    idx_t  hit_idx;
    logic  free_ok;
    idx_t  free_idx;
    dist_t free_dist;
    logic  all_ok;
    idx_t  all_idx;
    dist_t all_dist;
    rgb_t  all_col;
  } tok_t;

  typedef struct packed {
    logic wr_en;
    logic set_en;
    idx_t wr_idx;
    idx_t set_idx;
    rgb_t col;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;
endpackage

// ===== hw/rtl/pca_cell.sv =====
// pca_cell: one palette entry (colour and allocated flag) and one stage of the
// search word chain. Depends on pca_pkg.
module pca_cell
  import pca_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  idx_t cell_idx,
  input  logic in_use,
  input  logic flag_init,
  input  wr_t  wr,
  input  tok_t tok_in,
  output tok_t tok_out
);
  rgb_t col;
  logic flag;
  tok_t tok_next;
  logic valid_q;
  tok_t tok_q;

  logic [CHAN_W-1:0] mr, mg, mb;
  logic [7:0] qr, qg, qb;
  logic [15:0] sr, sg, sb;
  dist_t sq_dist;
  logic active, match;

  always_comb begin
    mr = (col.r >= tok_in.req.r) ? col.r - tok_in.req.r : tok_in.req.r - col.r;
    mg = (col.g >= tok_in.req.g) ? col.g - tok_in.req.g : tok_in.req.g - col.g;
    mb = (col.b >= tok_in.req.b) ? col.b - tok_in.req.b : tok_in.req.b - col.b;
    qr = mr[15:8];
    qg = mg[15:8];
    qb = mb[15:8];
    sr = 16'(qr * qr);
    sg = 16'(qg * qg);
    sb = 16'(qb * qb);
    sq_dist = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    active = tok_in.valid & in_use;
    match = (col == tok_in.req);
    tok_next = tok_in;
    if (active && match) begin
      tok_next.hit_ok  = 1'b1;
      tok_next.hit_idx = cell_idx;
    end
    if (active && !flag && (!tok_in.free_ok || sq_dist < tok_in.free_dist)) begin
      tok_next.free_ok   = 1'b1;
      tok_next.free_idx  = cell_idx;
      tok_next.free_dist = sq_dist;
    end
    if (active && (!tok_in.all_ok || sq_dist < tok_in.all_dist)) begin
      tok_next.all_ok   = 1'b1;
      tok_next.all_idx  = cell_idx;
      tok_next.all_dist = sq_dist;
      tok_next.all_col  = col;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_en && wr.wr_idx == cell_idx) begin
      col <= wr.col;
    end
    tok_q <= tok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag    <= flag_init;
      valid_q <= 1'b0;
    end else begin
      if (wr.set_en && wr.set_idx == cell_idx) begin
        flag <= 1'b1;
      end
      valid_q <= tok_in.valid;
    end
  end

  always_comb begin
    tok_out = tok_q;
    tok_out.valid = valid_q;
  end
endmodule

// ===== hw/rtl/palette_colour_allocator.sv =====
// palette_colour_allocator: top level; config register, sequencer, cell chain.
// Depends on pca_pkg and pca_cell.
// Sequence: a load word is written into its entry when it is accepted; a request
// word makes one pass of the search word down the cell chain to its grant, then
// a finish state that waits while a waiting grant holds the output.
// Flow: one word at a time; after a request the next word can be taken in the
// cycle in which its grant first shows on the output.
// Reset: flags of entries 0 and 1 set, others clear; num_colours = 256;
// colours are undefined until loaded.
module palette_colour_allocator
  import pca_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [7:0]         entry_index,
  input  logic [15:0]        req_red,
  input  logic [15:0]        req_green,
  input  logic [15:0]        req_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         outcome,
  output logic [7:0]         pixel,
  output logic [15:0]        got_red,
  output logic [15:0]        got_green,
  output logic [15:0]        got_blue
);
  logic [CNT_W-1:0] num_colours;
  state_t state, state_next;
  tok_t tok [PAL_DEPTH+1];
  tok_t fin;
  wr_t  wr;
  logic accept, slot_free, done, any;
  rgb_t out_col;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NUM_COLOURS) ? 32'(num_colours) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_colours <= NUM_COLOURS_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_NUM_COLOURS) begin
      num_colours <= pwdata[CNT_W-1:0];
    end
  end

  assign accept    = in_valid & in_ready;
  assign slot_free = !out_valid || out_ready;
  assign any       = fin.hit_ok | fin.free_ok | fin.all_ok;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && action) state_next = ST_SCAN;
      ST_SCAN:   if (tok[PAL_DEPTH].valid) state_next = ST_FINISH;
      ST_FINISH: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    done     = (state == ST_FINISH) && slot_free;
    wr = '0;
    wr.col = fin.req;
    if (accept && !action) begin
      wr.wr_en  = 1'b1;
      wr.wr_idx = entry_index;
      wr.col    = '{r: req_red, g: req_green, b: req_blue};
    end else if (done && fin.hit_ok) begin
      wr.set_en  = 1'b1;
      wr.set_idx = fin.hit_idx;
    end else if (done && fin.free_ok) begin
      wr.wr_en   = 1'b1;
      wr.wr_idx  = fin.free_idx;
      wr.set_en  = 1'b1;
      wr.set_idx = fin.free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = accept & action;
    tok[0].req   = '{r: req_red, g: req_green, b: req_blue};
  end

  for (genvar i = 0; i < PAL_DEPTH; i++) begin : g_cell
    pca_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(i)),
      .in_use    (CNT_W'(i) < num_colours),
      .flag_init (i < 2),
      .wr        (wr),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && tok[PAL_DEPTH].valid) begin
      fin <= tok[PAL_DEPTH];
    end
  end

  always_comb begin
    out_col = fin.hit_ok || fin.free_ok ? fin.req : fin.all_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && any) begin
      outcome   <= fin.hit_ok ? OUT_EXACT : (fin.free_ok ? OUT_FREE : OUT_NEAR);
      pixel     <= fin.hit_ok ? fin.hit_idx : (fin.free_ok ? fin.free_idx : fin.all_idx);
      got_red   <= out_col.r;
      got_green <= out_col.g;
      got_blue  <= out_col.b;
    end
  end
endmodule
